### rtl/bhpq_pkg.sv
// shared operation and status codes for the binary heap priority queue
package bhpq_pkg;

    localparam int STATUS_BITS = 2;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

endpackage

### rtl/bhpq_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/binary_heap_priority_queue.sv
// bounded binary heap priority queue with entries held in one ram
//
//  channel   direction  handshake                     payload
//  command   in         start, busy                   i_func, i_key, i_payload
//  result    out        o_done (one-cycle strobe)     o_status, o_out_valid, o_out_key,
//                                                     o_out_payload, o_occupancy
//  config    in         i_cfg_we                      i_cfg_wdata
//
// insert: S_UP moves the new entry up a level while its parent ranks behind it
// remove: root and last entry are read, then per level S_DN_L and S_DN_R read both children in turn
// the single read port of the heap ram sets the pace
// a full insert or an empty remove answers in the cycle after it is accepted
// synchronous reset empties the heap; ram contents are left as they are
// results cannot be held off: o_done marks each beat for one cycle only
module binary_heap_priority_queue #(
    parameter int CAPACITY     = 1024,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [KEY_BITS-1:0]                i_key,
    input  logic [PAYLOAD_BITS-1:0]            i_payload,
    output logic                               o_done,
    output logic [bhpq_pkg::STATUS_BITS-1:0]   o_status,
    output logic                               o_out_valid,
    output logic [KEY_BITS-1:0]                o_out_key,
    output logic [PAYLOAD_BITS-1:0]            o_out_payload,
    output logic [$clog2(CAPACITY+1)-1:0]      o_occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 1;
    localparam int DW = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_L,
        S_DN_R,
        S_FIN
    } t_state;

    t_state                            r_state, n_state;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [AW-1:0]                     r_idx, n_idx;
    logic [DW-1:0]                     r_mov, n_mov;
    logic [DW-1:0]                     r_lc, n_lc;
    logic                              r_lf;
    logic                              r_done, n_done;
    logic [bhpq_pkg::STATUS_BITS-1:0]  r_status, n_status;
    logic                              r_ovalid, n_ovalid;
    logic [KEY_BITS-1:0]               r_okey, n_okey;
    logic [PAYLOAD_BITS-1:0]           r_opay, n_opay;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [DW-1:0]                     ram_wdata;
    logic [AW-1:0]                     ram_raddr;
    logic [DW-1:0]                     ram_rdata;

    logic [KEY_BITS-1:0]               rd_key, mov_key, lc_key;
    logic [AW-1:0]                     slot, in_parent, up_p, up_pp;
    logic [XW-1:0]                     cnt_x, dn_l, dn_r, best_idx, best_l;
    logic                              best_right, dn_swap;
    logic [DW-1:0]                     best_ent;
    logic                              accept;

    function automatic logic behind(input logic lf, input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
        behind = lf ? (a < b) : (a > b);
    endfunction

    bhpq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept     = start && !busy;
    assign rd_key     = ram_rdata[DW-1 -: KEY_BITS];
    assign mov_key    = r_mov[DW-1 -: KEY_BITS];
    assign lc_key     = r_lc[DW-1 -: KEY_BITS];
    assign slot       = r_cnt[AW-1:0];
    assign in_parent  = (slot - 1'b1) >> 1;
    assign up_p       = (r_idx - 1'b1) >> 1;
    assign up_pp      = (up_p - 1'b1) >> 1;
    assign cnt_x      = XW'(r_cnt);
    assign dn_l       = {r_idx, 1'b1};
    assign dn_r       = dn_l + 1'b1;
    // right child wins unless it ranks behind the left one
    assign best_right = !behind(r_lf, rd_key, lc_key);
    assign best_idx   = best_right ? dn_r : dn_l;
    assign best_ent   = best_right ? ram_rdata : r_lc;
    assign best_l     = {best_idx[AW-1:0], 1'b1};
    assign dn_swap    = behind(r_lf, mov_key, lc_key) || behind(r_lf, mov_key, rd_key);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_mov     = r_mov;
        n_lc      = r_lc;
        n_done    = 1'b0;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_okey    = r_okey;
        n_opay    = r_opay;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_mov;
        ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ovalid = 1'b0;
                    n_okey   = '0;
                    n_opay   = '0;
                    n_status = bhpq_pkg::STATUS_DONE;
                    if (i_func == bhpq_pkg::FUNC_INSERT) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_status = bhpq_pkg::STATUS_FULL;
                            n_done   = 1'b1;
                        end else begin
                            n_cnt     = r_cnt + 1'b1;
                            n_mov     = {i_key, i_payload};
                            n_idx     = slot;
                            ram_raddr = in_parent;
                            n_state   = (slot == '0) ? S_FIN : S_UP;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = bhpq_pkg::STATUS_EMPTY;
                            n_done   = 1'b1;
                        end else begin
                            n_cnt     = r_cnt - 1'b1;
                            n_ovalid  = 1'b1;
                            ram_raddr = '0;
                            n_state   = S_RM_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                if (behind(r_lf, rd_key, mov_key)) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_raddr = up_pp;
                    n_idx     = up_p;
                    n_state   = (up_p == '0) ? S_FIN : S_UP;
                end else begin
                    ram_we  = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RM_ROOT: begin
                n_okey = rd_key;
                n_opay = ram_rdata[PAYLOAD_BITS-1:0];
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = r_cnt[AW-1:0];
                    n_state   = S_RM_LAST;
                end
            end
            S_RM_LAST: begin
                n_mov = ram_rdata;
                n_idx = '0;
                if (r_cnt == CW'(1)) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = ram_rdata;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    ram_raddr = AW'(1);
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                if (dn_r < cnt_x) begin
                    n_lc      = ram_rdata;
                    ram_raddr = dn_r[AW-1:0];
                    n_state   = S_DN_R;
                end else if (behind(r_lf, mov_key, rd_key)) begin
                    // lone left child is a leaf
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_idx     = dn_l[AW-1:0];
                    n_state   = S_FIN;
                end else begin
                    ram_we  = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DN_R: begin
                if (dn_swap) begin
                    ram_we    = 1'b1;
                    ram_wdata = best_ent;
                    ram_raddr = best_l[AW-1:0];
                    n_idx     = best_idx[AW-1:0];
                    n_state   = (best_l < cnt_x) ? S_DN_L : S_FIN;
                end else begin
                    ram_we  = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                ram_we  = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_lf    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_lf <= i_cfg_wdata;
            end
        end
        r_idx    <= n_idx;
        r_mov    <= n_mov;
        r_lc     <= n_lc;
        r_status <= n_status;
        r_ovalid <= n_ovalid;
        r_okey   <= n_okey;
        r_opay   <= n_opay;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_valid   = r_ovalid;
    assign o_out_key     = r_okey;
    assign o_out_payload = r_opay;
    assign o_occupancy   = r_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_valid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_valid) |-> (o_status == bhpq_pkg::STATUS_DONE))
        else $error("returned entry with error status");

    a_sink_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_L) |-> (dn_l < cnt_x))
        else $error("sift-down read beyond last entry");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && ($past(busy) || $past(accept)))
        else $error("result beat without a finished command");

endmodule

### tb/tb_binary_heap_priority_queue.sv
// self-checking testbench for the binary heap priority queue with a heap predictor
module tb_binary_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 1024;
    localparam int KEY_BITS      = 32;
    localparam int PAYLOAD_BITS  = 32;
    localparam int OCC_BITS      = $clog2(CAPACITY + 1);
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 120;

    typedef enum logic [1:0] {BEAT_CMD, BEAT_CFG, BEAT_HOLD} t_beat_kind;

    typedef struct {
        t_beat_kind              kind;
        logic                    func;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    cfg;
        int unsigned             gap;
    } t_heap_cmd;

    typedef struct {
        logic [bhpq_pkg::STATUS_BITS-1:0] status;
        logic                             valid;
        logic [KEY_BITS-1:0]              key;
        logic [PAYLOAD_BITS-1:0]          payload;
        logic [OCC_BITS-1:0]              occupancy;
        longint unsigned                  issued_at;
    } t_heap_result;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic                             i_cfg_wdata = 1'b0;
    logic                             start       = 1'b0;
    logic                             busy;
    logic                             i_func      = bhpq_pkg::FUNC_INSERT;
    logic [KEY_BITS-1:0]              i_key       = '0;
    logic [PAYLOAD_BITS-1:0]          i_payload   = '0;
    logic                             o_done;
    logic [bhpq_pkg::STATUS_BITS-1:0] o_status;
    logic                             o_out_valid;
    logic [KEY_BITS-1:0]              o_out_key;
    logic [PAYLOAD_BITS-1:0]          o_out_payload;
    logic [OCC_BITS-1:0]              o_occupancy;

    binary_heap_priority_queue #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_out_valid   (o_out_valid),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_occupancy   (o_occupancy)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // heap predictor state
    logic                    serve_largest = 1'b0;
    logic [KEY_BITS-1:0]     shadow_keys [CAPACITY];
    logic [PAYLOAD_BITS-1:0] shadow_pays [CAPACITY];
    int unsigned             shadow_count = 0;

    t_heap_cmd    cmd_backlog [$];
    t_heap_result due_results [$];

    int unsigned burst_left = 0;
    int unsigned n_cmds     = 0;
    int unsigned n_issued   = 0;
    int unsigned n_seen     = 0;
    int unsigned gap_left   = 0;
    int unsigned cur_gap    = 0;
    int unsigned faults     = 0;
    int unsigned n_inserts  = 0;
    int unsigned n_removes  = 0;
    int unsigned n_dropped  = 0;
    int unsigned n_starved  = 0;

    function automatic bit ranks_behind(input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b);
        return serve_largest ? (a < b) : (a > b);
    endfunction

    function automatic void exchange_slots(input int unsigned a, input int unsigned b);
        logic [KEY_BITS-1:0]     k;
        logic [PAYLOAD_BITS-1:0] p;
        k = shadow_keys[a];
        shadow_keys[a] = shadow_keys[b];
        shadow_keys[b] = k;
        p = shadow_pays[a];
        shadow_pays[a] = shadow_pays[b];
        shadow_pays[b] = p;
    endfunction

    function automatic t_heap_result heap_apply(input logic func,
                                                input logic [KEY_BITS-1:0] key,
                                                input logic [PAYLOAD_BITS-1:0] payload);
        t_heap_result r;
        int unsigned  i;
        int unsigned  up;
        int unsigned  lc;
        int unsigned  rc;
        int unsigned  nxt;
        r = '{default: '0};
        r.status = bhpq_pkg::STATUS_DONE;
        if (func == bhpq_pkg::FUNC_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = bhpq_pkg::STATUS_FULL;
            end else begin
                i = shadow_count;
                shadow_keys[i] = key;
                shadow_pays[i] = payload;
                shadow_count++;
                while (i > 0) begin
                    up = (i - 1) / 2;
                    if (!ranks_behind(shadow_keys[up], shadow_keys[i]))
                        break;
                    exchange_slots(i, up);
                    i = up;
                end
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = bhpq_pkg::STATUS_EMPTY;
            end else begin
                r.valid   = 1'b1;
                r.key     = shadow_keys[0];
                r.payload = shadow_pays[0];
                shadow_count--;
                shadow_keys[0] = shadow_keys[shadow_count];
                shadow_pays[0] = shadow_pays[shadow_count];
                i = 0;
                while (1) begin
                    lc = 2 * i + 1;
                    rc = lc + 1;
                    if (lc >= shadow_count)
                        break;
                    if (rc >= shadow_count) begin
                        if (!ranks_behind(shadow_keys[i], shadow_keys[lc]))
                            break;
                        nxt = lc;
                    end else begin
                        if (!ranks_behind(shadow_keys[i], shadow_keys[lc]) &&
                            !ranks_behind(shadow_keys[i], shadow_keys[rc]))
                            break;
                        // tie between children goes right
                        nxt = ranks_behind(shadow_keys[rc], shadow_keys[lc]) ? lc : rc;
                    end
                    exchange_slots(i, nxt);
                    i = nxt;
                end
            end
        end
        r.occupancy = shadow_count[OCC_BITS-1:0];
        return r;
    endfunction

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_heap_cmd    head;
        t_heap_result want;
        bit           issue;
        bit           go;
        bit           we;
        issue = 1'b0;
        we    = 1'b0;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (start && !busy) begin
                issue = 1'b1;
                want = heap_apply(i_func, i_key, i_payload);
                want.issued_at = $time;
                due_results.push_back(want);
                n_issued++;
                if (i_func == bhpq_pkg::FUNC_INSERT) begin
                    n_inserts++;
                    if (want.status == bhpq_pkg::STATUS_FULL)
                        n_dropped++;
                end else begin
                    n_removes++;
                    if (want.status == bhpq_pkg::STATUS_EMPTY)
                        n_starved++;
                end
                gap_left = cur_gap;
            end
            go = start && !issue;
            if (!go) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() > 0) begin
                    head = cmd_backlog[0];
                    case (head.kind)
                        BEAT_CMD: begin
                            go = 1'b1;
                            i_func    <= head.func;
                            i_key     <= head.key;
                            i_payload <= head.payload;
                            cur_gap = head.gap;
                            void'(cmd_backlog.pop_front());
                        end
                        BEAT_CFG: begin
                            if (n_seen == n_issued && !busy) begin
                                we = 1'b1;
                                i_cfg_wdata <= head.cfg;
                                serve_largest = head.cfg;
                                void'(cmd_backlog.pop_front());
                            end
                        end
                        BEAT_HOLD: begin
                            if (n_seen == n_issued)
                                void'(cmd_backlog.pop_front());
                        end
                        default: void'(cmd_backlog.pop_front());
                    endcase
                end
            end
            start    <= go;
            i_cfg_we <= we;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && o_done) begin
            n_seen <= n_seen + 1;
            if (due_results.size() == 0 || due_results[0].issued_at >= $time) begin
                note_fault($sformatf({"unexpected beat status %0d valid %0d key %h",
                                      " payload %h occ %0d"},
                                     o_status, o_out_valid, o_out_key, o_out_payload,
                                     o_occupancy));
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status || o_out_valid !== want.valid ||
                    o_out_key !== want.key || o_out_payload !== want.payload ||
                    o_occupancy !== want.occupancy)
                    note_fault($sformatf({"expected status %0d valid %0d key %h payload %h occ %0d,",
                                          " got status %0d valid %0d key %h payload %h occ %0d"},
                                         want.status, want.valid, want.key, want.payload,
                                         want.occupancy, o_status, o_out_valid, o_out_key,
                                         o_out_payload, o_occupancy));
            end
        end
    end

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return KEY_BITS'($urandom_range(0, 7));
            1:       return '1 - KEY_BITS'($urandom_range(0, 7));
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    task automatic push_cmd(input logic func, input logic [KEY_BITS-1:0] key,
                            input logic [PAYLOAD_BITS-1:0] payload);
        t_heap_cmd c;
        c.kind    = BEAT_CMD;
        c.func    = func;
        c.key     = key;
        c.payload = payload;
        c.cfg     = 1'b0;
        if (burst_left > 0) begin
            c.gap = 0;
            burst_left--;
        end else begin
            c.gap = $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 12);
        end
        n_cmds++;
        cmd_backlog.push_back(c);
    endtask

    task automatic push_ctl(input t_beat_kind kind, input logic value);
        t_heap_cmd c;
        c = '{kind: kind, func: bhpq_pkg::FUNC_INSERT, key: '0, payload: '0, cfg: value, gap: 0};
        cmd_backlog.push_back(c);
    endtask

    initial begin
        int unsigned ins_pct [4];
        logic        phase_order [4];
        int          p;
        int          n;
        ins_pct     = '{70, 45, 25, 60};
        phase_order = '{1'b1, 1'b0, 1'b1, 1'b0};

        // smallest first: empty heap, extremes, tied children on the way down
        push_ctl(BEAT_CFG, 1'b0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '1, '1);
        push_cmd(bhpq_pkg::FUNC_INSERT, '0, '0);
        push_cmd(bhpq_pkg::FUNC_INSERT, '1, '1);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '1, '1);
        push_cmd(bhpq_pkg::FUNC_INSERT, 32'd1, 32'h0000_00A1);
        push_cmd(bhpq_pkg::FUNC_INSERT, 32'd2, 32'h0000_00B2);
        push_cmd(bhpq_pkg::FUNC_INSERT, 32'd2, 32'h0000_00C3);
        push_cmd(bhpq_pkg::FUNC_INSERT, 32'd9, 32'h0000_00D4);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);

        // largest first
        push_ctl(BEAT_CFG, 1'b1);
        push_cmd(bhpq_pkg::FUNC_INSERT, 32'd7, 32'h5555_5555);
        push_cmd(bhpq_pkg::FUNC_INSERT, 32'd7, 32'hAAAA_AAAA);
        push_cmd(bhpq_pkg::FUNC_INSERT, '1, 32'h0F0F_0F0F);
        push_cmd(bhpq_pkg::FUNC_INSERT, '0, 32'hF0F0_F0F0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);
        push_cmd(bhpq_pkg::FUNC_REMOVE, '0, '0);

        for (p = 0; p < 4; p++) begin
            push_ctl(BEAT_CFG, phase_order[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    push_ctl(BEAT_HOLD, 1'b0);
                if ($urandom_range(0, 99) < ins_pct[p])
                    push_cmd(bhpq_pkg::FUNC_INSERT, pick_key(), PAYLOAD_BITS'($urandom));
                else
                    push_cmd(bhpq_pkg::FUNC_REMOVE, KEY_BITS'($urandom),
                             PAYLOAD_BITS'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_issued != n_cmds || n_seen < n_issued)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (due_results.size() != 0)
            note_fault($sformatf("%0d results never arrived", due_results.size()));

        $display("covered %0d inserts (%0d dropped) and %0d removes (%0d on an empty heap)",
                 n_inserts, n_dropped, n_removes, n_starved);
        $display("in both service orders, with tied and extreme keys, bursts and pauses");
        if (faults == 0)
            $display("PASS binary_heap_priority_queue");
        else
            $display("FAIL binary_heap_priority_queue");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL binary_heap_priority_queue");
        $finish;
    end

endmodule
